// File: sv/lmcfw_pkg.sv
// Shared types, constants and init table for the LED-matrix chain frame writer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package lmcfw_pkg;

  localparam int DEVICES   = 4;
  localparam int NCOLS     = DEVICES * 8;
  localparam int COL_W     = $clog2(NCOLS);
  localparam int DEV_W     = 2;
  localparam int FRAME_W   = 64;
  localparam int INIT_STEPS = 5;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_SET_COL   = 3'd1;
  localparam logic [2:0] OP_SET_PIXEL = 3'd2;
  localparam logic [2:0] OP_COMMIT    = 3'd3;
  localparam logic [2:0] OP_WRITE_ONE = 3'd4;
  localparam logic [2:0] OP_WRITE_ALL = 3'd5;

  localparam logic [7:0] REG_DECODE    = 8'h09;
  localparam logic [7:0] REG_INTENSITY = 8'h0A;
  localparam logic [7:0] REG_SCANLIMIT = 8'h0B;
  localparam logic [7:0] REG_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] REG_DISPTEST  = 8'h0F;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] column;
    logic [2:0] row_bit;
    logic [7:0] value;
    logic [1:0] device;
    logic [7:0] reg_addr;
  } lmcfw_cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               last;
  } lmcfw_res_t;

  // One word for one device, handed from the sequencer to the frame builder.
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [7:0]       reg_addr;
    logic [7:0]       data;
    logic             last;
  } lmcfw_word_req_t;

  // Register written by each step of the per-device init sequence.
  function automatic logic [7:0] init_reg(input logic [2:0] step);
    logic [7:0] r;
    case (step)
      3'd0:    r = REG_DISPTEST;
      3'd1:    r = REG_SCANLIMIT;
      3'd2:    r = REG_DECODE;
      3'd3:    r = REG_INTENSITY;
      3'd4:    r = REG_SHUTDOWN;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] init_data(input logic [2:0] step);
    logic [7:0] d;
    case (step)
      3'd1:    d = 8'd7;
      3'd4:    d = 8'd1;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/lmcfw_store.sv
// Column store: memory with one write port, one registered read port and per-entry valid bits.
// Depends on lmcfw_pkg. An entry not written since reset or clear reads as zero.
`timescale 1ns / 1ps

module lmcfw_store
  import lmcfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0]       mem [NCOLS];
  logic [NCOLS-1:0] valid;
  logic [7:0]       mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        valid_q <= valid[raddr];
      end
    end
  end

  assign rdata = valid_q ? mem_q : 8'h00;

endmodule

// File: sv/lmcfw_frame_unit.sv
// Shared frame builder and output request register.
// Depends on lmcfw_pkg. Places one (register, data) word at its device slot.
`timescale 1ns / 1ps

module lmcfw_frame_unit
  import lmcfw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  lmcfw_word_req_t req,
  output logic            free,
  output logic            res_valid,
  input  logic            res_stall,
  output lmcfw_res_t      res
);

  localparam logic [DEV_W-1:0] LAST_DEV = DEV_W'(DEVICES - 1);

  logic [DEV_W-1:0]   slot;
  logic [FRAME_W-1:0] frame_next;

  // Device 0 sits in the most significant used word.
  assign slot       = LAST_DEV - req.dev;
  assign frame_next = FRAME_W'({req.reg_addr, req.data}) << {slot, 4'b0000};
  assign free       = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_valid && free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && free) begin
      res.frame <= frame_next;
      res.last  <= req.last;
    end
  end

endmodule

// File: sv/led_matrix_chain_frame_writer_core.sv
// Top level of the LED-matrix chain frame writer: command sequencer.
// Depends on lmcfw_pkg, lmcfw_store and lmcfw_frame_unit.
`timescale 1ns / 1ps

// Takes one command at a time and turns it into 64-bit chain frames, each
// with one 16-bit (register, data) word at its device's slot (device 0 in
// the top used word) and zero no-op words elsewhere; the final frame of a
// command has last set. Clear and set column finish in the accepting cycle;
// set pixel reads the column, then writes the merged byte back. Commit reads
// each column from the store (S_CRD), then hands it to the shared frame
// builder (S_CEMIT). Write one device sends one frame, write all one frame
// per device. The first command that sends any frame is preceded by the
// 20-frame init sequence (5 frames per device, one a cycle while the result
// channel does not stall). Result stalls hold the sequencer; cmd_stall is
// high while a command is in progress. Out-of-range columns and devices,
// and unknown opcodes, are dropped without frames.

module led_matrix_chain_frame_writer_core
  import lmcfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  lmcfw_cmd_t cmd,
  output logic       res_valid,
  input  logic       res_stall,
  output lmcfw_res_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_CRD   = 3'd3;
  localparam logic [2:0] S_CEMIT = 3'd4;
  localparam logic [2:0] S_ONE   = 3'd5;
  localparam logic [2:0] S_ALL   = 3'd6;

  localparam logic [DEV_W-1:0] LAST_DEV  = DEV_W'(DEVICES - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(NCOLS - 1);
  localparam logic [2:0]       LAST_STEP = 3'(INIT_STEPS - 1);

  logic [2:0]       state, state_next;
  logic             init_done, init_done_next;
  logic [DEV_W-1:0] dev_cnt, dev_cnt_next;
  logic [2:0]       step_cnt, step_cnt_next;
  logic [COL_W-1:0] col_cnt, col_cnt_next;
  lmcfw_cmd_t       cmd_q;

  logic             accept;
  logic             col_ok, dev_ok;
  logic             st_clear, st_we, st_re;
  logic [COL_W-1:0] st_waddr, st_raddr;
  logic [7:0]       st_wdata, st_rdata;
  logic             req_valid, free;
  lmcfw_word_req_t  req;
  logic [2:0]       after_init;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign col_ok    = {1'b0, cmd.column} < 7'(NCOLS);
  assign dev_ok    = {1'b0, cmd.device} < 3'(DEVICES);

  // Where the command goes once the init sequence is out.
  always_comb begin
    case (cmd_q.opcode)
      OP_COMMIT:    after_init = S_CRD;
      OP_WRITE_ONE: after_init = S_ONE;
      default:      after_init = S_ALL;
    endcase
  end

  lmcfw_store u_store (
    .clk   (clk),
    .rst   (rst),
    .clear (st_clear),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lmcfw_frame_unit u_frame (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always_comb begin
    state_next     = state;
    init_done_next = init_done;
    dev_cnt_next   = dev_cnt;
    step_cnt_next  = step_cnt;
    col_cnt_next   = col_cnt;
    st_clear       = 1'b0;
    st_we          = 1'b0;
    st_waddr       = cmd.column[COL_W-1:0];
    st_wdata       = cmd.value;
    st_re          = 1'b0;
    st_raddr       = cmd.column[COL_W-1:0];
    req_valid      = 1'b0;
    req            = '0;

    case (state)
      S_IDLE: begin
        dev_cnt_next  = '0;
        step_cnt_next = '0;
        col_cnt_next  = '0;
        if (accept) begin
          case (cmd.opcode)
            OP_CLEAR: begin
              st_clear = 1'b1;
            end
            OP_SET_COL: begin
              st_we = col_ok;
            end
            OP_SET_PIXEL: begin
              // Read now, merge the bit and write back next cycle.
              if (col_ok) begin
                st_re      = 1'b1;
                state_next = S_PIX;
              end
            end
            OP_COMMIT: begin
              state_next = init_done ? S_CRD : S_INIT;
            end
            OP_WRITE_ONE: begin
              if (dev_ok) begin
                state_next = init_done ? S_ONE : S_INIT;
              end
            end
            OP_WRITE_ALL: begin
              state_next = init_done ? S_ALL : S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      S_PIX: begin
        st_we      = 1'b1;
        st_waddr   = cmd_q.column[COL_W-1:0];
        st_wdata   = st_rdata | (8'h01 << cmd_q.row_bit);
        state_next = S_IDLE;
      end

      S_INIT: begin
        req_valid    = 1'b1;
        req.dev      = dev_cnt;
        req.reg_addr = init_reg(step_cnt);
        req.data     = init_data(step_cnt);
        req.last     = 1'b0;
        if (free) begin
          if (step_cnt == LAST_STEP) begin
            step_cnt_next = '0;
            if (dev_cnt == LAST_DEV) begin
              dev_cnt_next   = '0;
              init_done_next = 1'b1;
              state_next     = after_init;
            end else begin
              dev_cnt_next = dev_cnt + 1'b1;
            end
          end else begin
            step_cnt_next = step_cnt + 1'b1;
          end
        end
      end

      S_CRD: begin
        st_re      = 1'b1;
        st_raddr   = col_cnt;
        state_next = S_CEMIT;
      end

      S_CEMIT: begin
        req_valid    = 1'b1;
        req.dev      = DEV_W'(col_cnt >> 3);
        req.reg_addr = 8'(col_cnt[2:0]) + 8'd1;
        req.data     = st_rdata;
        req.last     = (col_cnt == LAST_COL);
        if (free) begin
          if (col_cnt == LAST_COL) begin
            state_next = S_IDLE;
          end else begin
            col_cnt_next = col_cnt + 1'b1;
            state_next   = S_CRD;
          end
        end
      end

      S_ONE: begin
        req_valid    = 1'b1;
        req.dev      = cmd_q.device;
        req.reg_addr = cmd_q.reg_addr;
        req.data     = cmd_q.value;
        req.last     = 1'b1;
        if (free) begin
          state_next = S_IDLE;
        end
      end

      S_ALL: begin
        req_valid    = 1'b1;
        req.dev      = dev_cnt;
        req.reg_addr = cmd_q.reg_addr;
        req.data     = cmd_q.value;
        req.last     = (dev_cnt == LAST_DEV);
        if (free) begin
          if (dev_cnt == LAST_DEV) begin
            state_next = S_IDLE;
          end else begin
            dev_cnt_next = dev_cnt + 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      init_done <= 1'b0;
      dev_cnt   <= '0;
      step_cnt  <= '0;
      col_cnt   <= '0;
    end else begin
      state     <= state_next;
      init_done <= init_done_next;
      dev_cnt   <= dev_cnt_next;
      step_cnt  <= step_cnt_next;
      col_cnt   <= col_cnt_next;
    end
  end

  // Hold the accepted request for the whole command.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

endmodule

// File: verif/led_matrix_chain_frame_writer_core_test.sv
// Self-checking testbench for led_matrix_chain_frame_writer_core: directed table, then random
// requests, every frame checked against its table row or a local model of store and init.
// Depends on lmcfw_pkg and the core RTL.
`timescale 1ns / 1ps

module led_matrix_chain_frame_writer_core_test;
  import lmcfw_pkg::*;

  // Opcodes the block must drop without sending anything
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  lmcfw_cmd_t cmd;
  logic       res_valid;
  logic       res_stall;
  lmcfw_res_t res;

  led_matrix_chain_frame_writer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // One row of the directed table. When frame_known is set the row carries its own answer
  // (n_frames is 0 or 1, and a single frame is always the last one of its request).
  typedef struct {
    lmcfw_cmd_t  req;
    bit          frame_known;
    int          n_frames;
    logic [63:0] frame;
  } step_row_t;

  // Local copy of the block's state
  logic [7:0] mirror_cols [NCOLS];
  bit         mirror_primed;

  lmcfw_res_t frames_due[$];   // frames still owed by the block, oldest first
  lmcfw_res_t cmd_frames[$];   // frames caused by the request being modelled
  step_row_t  script[$];
  int         error_count;
  bit         quiet;           // no gaps and no stalls while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit: ends a hung run with an error report.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length: mostly none, often short, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Place one (register, data) word at device dev, zero no-op words elsewhere
  function automatic logic [FRAME_W-1:0] chain_frame(input int dev, input logic [7:0] ra,
                                                     input logic [7:0] data);
    logic [FRAME_W-1:0] f;
    f = {{(FRAME_W-16){1'b0}}, ra, data};
    return f << (16 * (DEVICES - 1 - dev));
  endfunction

  function automatic void queue_word(input int dev, input logic [7:0] ra, input logic [7:0] data);
    lmcfw_res_t r;
    r.frame = chain_frame(dev, ra, data);
    r.last  = 1'b0;
    cmd_frames.push_back(r);
  endfunction

  // Wake-up words go out once, ahead of the first request that sends anything
  function automatic void prime_chain();
    logic [7:0] ra;
    logic [7:0] data;
    if (mirror_primed) return;
    mirror_primed = 1'b1;
    for (int dev = 0; dev < DEVICES; dev++)
      for (int wake_ix = 0; wake_ix < INIT_STEPS; wake_ix++) begin
        case (wake_ix)
          0: begin ra = REG_DISPTEST;  data = 8'd0; end
          1: begin ra = REG_SCANLIMIT; data = 8'd7; end
          2: begin ra = REG_DECODE;    data = 8'd0; end
          3: begin ra = REG_INTENSITY; data = 8'd0; end
          default: begin ra = REG_SHUTDOWN; data = 8'd1; end
        endcase
        queue_word(dev, ra, data);
      end
  endfunction

  // Apply one request to the local state and collect the frames it causes in cmd_frames
  function automatic void run_command(input lmcfw_cmd_t c);
    lmcfw_res_t r;
    cmd_frames.delete();
    case (c.opcode)
      OP_CLEAR:     foreach (mirror_cols[i]) mirror_cols[i] = 8'h00;
      OP_SET_COL:   if (c.column < NCOLS) mirror_cols[c.column] = c.value;
      OP_SET_PIXEL: if (c.column < NCOLS) mirror_cols[c.column][c.row_bit] = 1'b1;
      OP_COMMIT: begin
        prime_chain();
        for (int col = 0; col < NCOLS; col++)
          queue_word(col / 8, 8'(col % 8 + 1), mirror_cols[col]);
      end
      OP_WRITE_ONE: begin
        if (c.device < DEVICES) begin
          prime_chain();
          queue_word(c.device, c.reg_addr, c.value);
        end
      end
      OP_WRITE_ALL: begin
        prime_chain();
        for (int dev = 0; dev < DEVICES; dev++) queue_word(dev, c.reg_addr, c.value);
      end
      default: ;
    endcase
    // Mark the closing frame of the request
    if (cmd_frames.size() > 0) begin
      r = cmd_frames.pop_back();
      r.last = 1'b1;
      cmd_frames.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic [2:0] op, input int col, input int rb,
                                  input int val, input int dev, input int ra,
                                  input bit known, input int n, input logic [63:0] f);
    step_row_t row;
    row.req.opcode   = op;
    row.req.column   = 6'(col);
    row.req.row_bit  = 3'(rb);
    row.req.value    = 8'(val);
    row.req.device   = 2'(dev);
    row.req.reg_addr = 8'(ra);
    row.frame_known  = known;
    row.n_frames     = n;
    row.frame        = f;
    script.push_back(row);
  endfunction

  // Random request; dropped is set for requests the block ignores outright
  function automatic lmcfw_cmd_t random_cmd(output bit dropped);
    lmcfw_cmd_t c;
    int pick;
    c.column   = 6'($urandom_range(0, NCOLS - 1));
    c.row_bit  = 3'($urandom_range(0, 7));
    c.value    = 8'($urandom_range(0, 255));
    c.device   = 2'($urandom_range(0, 3));
    c.reg_addr = 8'($urandom_range(0, 255));
    dropped    = 1'b0;
    pick       = $urandom_range(0, 99);
    if (pick < 30)      c.opcode = OP_SET_COL;
    else if (pick < 50) c.opcode = OP_SET_PIXEL;
    else if (pick < 58) c.opcode = OP_COMMIT;
    else if (pick < 73) c.opcode = OP_WRITE_ONE;
    else if (pick < 83) c.opcode = OP_WRITE_ALL;
    else if (pick < 87) c.opcode = OP_CLEAR;
    else if (pick < 95) begin
      // Column beyond the chain: must leave the store alone
      c.opcode = $urandom_range(0, 1) ? OP_SET_COL : OP_SET_PIXEL;
      c.column = 6'($urandom_range(NCOLS, 63));
      dropped  = 1'b1;
    end else begin
      c.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      dropped  = 1'b1;
    end
    return c;
  endfunction

  // Offer one request, hold it until taken, then book its frames.
  // Frames of a request can only appear after the edge that takes it, so booking here
  // never races with the result checker.
  task automatic push_command(input lmcfw_cmd_t c, input bit known, input int n_known,
                              input logic [63:0] known_frame);
    lmcfw_res_t r;
    int gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    run_command(c);
    if (known) begin
      if (n_known > 0) begin
        r.frame = known_frame;
        r.last  = 1'b1;
        frames_due.push_back(r);
      end
    end else begin
      foreach (cmd_frames[k]) frames_due.push_back(cmd_frames[k]);
    end
    gap = quiet ? 0 : pick_gap();
    // Keep valid high for back-to-back requests; drop it only for a real gap
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new requests until the block has sent everything owed
  task automatic hold_until_drained();
    cmd_valid <= 1'b0;
    while (frames_due.size() > 0) @(posedge clk);
  endtask

  task automatic flag_result(input string what, input lmcfw_res_t want, input lmcfw_res_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s: expected frame %h last %b, got frame %h last %b",
               $time, what, want.frame, want.last, got.frame, got.last);
  endtask

  // Result stall: open windows of random length, broken by short and occasional long stalls
  initial begin : res_stall_gen
    int hold;
    int open_run;
    res_stall <= 1'b0;
    forever begin
      open_run = $urandom_range(1, 12);
      repeat (open_run) @(posedge clk);
      hold = quiet ? 0 : pick_gap();
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Compare every taken frame with the oldest one owed
  always @(posedge clk) begin : res_check
    lmcfw_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (frames_due.size() == 0) begin
        want = '0;
        flag_result("frame with nothing owed", want, res);
      end else begin
        want = frames_due.pop_front();
        if (res.frame !== want.frame || res.last !== want.last)
          flag_result("frame mismatch", want, res);
      end
    end
  end

  initial begin : stimulus
    lmcfw_cmd_t c;
    bit dropped;
    int counted;
    rst         <= 1'b1;
    cmd_valid   <= 1'b0;
    cmd         <= '0;
    quiet        = 1'b0;
    error_count  = 0;
    mirror_primed = 1'b0;
    foreach (mirror_cols[i]) mirror_cols[i] = 8'h00;

    // Directed table: op, column, row bit, value, device, reg, answer known, frames, frame
    add_row(OP_CLEAR,     0,  0, 8'h00, 0, 8'h00, 1, 0, '0);
    add_row(OP_SET_COL,   0,  0, 8'hFF, 0, 8'h00, 1, 0, '0);
    add_row(OP_SET_COL,   31, 0, 8'h80, 3, 8'hFF, 1, 0, '0);
    add_row(OP_SET_COL,   32, 0, 8'hAA, 0, 8'h00, 1, 0, '0);   // first column past the chain
    add_row(OP_SET_COL,   63, 7, 8'h55, 3, 8'hFF, 1, 0, '0);   // highest column index
    add_row(OP_SET_PIXEL, 5,  0, 8'h00, 0, 8'h00, 1, 0, '0);
    add_row(OP_SET_PIXEL, 5,  7, 8'hFF, 0, 8'h00, 1, 0, '0);
    add_row(OP_SET_PIXEL, 40, 3, 8'h00, 0, 8'h00, 1, 0, '0);   // pixel past the chain
    add_row(OP_SPARE_6,   63, 7, 8'hFF, 3, 8'hFF, 1, 0, '0);
    add_row(OP_SPARE_7,   0,  0, 8'h00, 0, 8'h00, 1, 0, '0);
    add_row(OP_COMMIT,    0,  0, 8'h00, 0, 8'h00, 0, 0, '0);   // wake-up words plus a full commit
    add_row(OP_WRITE_ONE, 0,  0, 8'hFF, 0, 8'hFF, 1, 1, 64'hFFFF_0000_0000_0000);
    add_row(OP_WRITE_ONE, 0,  0, 8'h00, 3, 8'h00, 1, 1, 64'h0000_0000_0000_0000);
    add_row(OP_WRITE_ONE, 0,  0, 8'h5A, 1, 8'hA5, 1, 1, 64'h0000_A55A_0000_0000);
    add_row(OP_WRITE_ONE, 0,  0, 8'h80, 2, 8'h01, 1, 1, 64'h0000_0000_0180_0000);
    add_row(OP_WRITE_ALL, 0,  0, 8'h0F, 0, 8'h0A, 0, 0, '0);
    add_row(OP_SET_PIXEL, 31, 0, 8'h00, 0, 8'h00, 1, 0, '0);
    add_row(OP_SET_COL,   16, 0, 8'h3C, 0, 8'h00, 1, 0, '0);
    add_row(OP_COMMIT,    0,  0, 8'h00, 0, 8'h00, 0, 0, '0);
    add_row(OP_CLEAR,     63, 7, 8'hFF, 3, 8'hFF, 1, 0, '0);
    add_row(OP_COMMIT,    0,  0, 8'h00, 0, 8'h00, 0, 0, '0);   // all-zero store
    add_row(OP_WRITE_ALL, 0,  0, 8'h00, 0, 8'hFF, 0, 0, '0);
    add_row(OP_WRITE_ALL, 0,  0, 8'hFF, 0, 8'h00, 0, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      push_command(script[i].req, script[i].frame_known, script[i].n_frames, script[i].frame);
    hold_until_drained();

    // Random part; only requests the block acts on count towards the total
    counted = 0;
    while (counted < 175) begin
      c = random_cmd(dropped);
      if (!dropped) counted++;
      // Run a stretch flat out on both sides
      quiet = (counted >= 80 && counted < 120);
      if (counted == 150 && !dropped) hold_until_drained();
      push_command(c, 1'b0, 0, '0);
    end
    quiet = 1'b0;

    // Drain, then watch a while for anything extra
    cmd_valid <= 1'b0;
    while (frames_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (error_count == 0 && frames_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
